@@ src/pps_pkg.sv @@
package pps_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int TIME_W    = 24;
   localparam int ENTRY_W   = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_TICK    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  prio;
      logic [15:0] arrival;
      logic [15:0] burst;
   } task_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SWEEP,
      ST_SCAN,
      ST_UPDATE,
      ST_FIGURE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_wr;
      logic sweep;
      logic scan;
      logic clr_cnt;
      logic update;
      logic figure;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       issue_done;
      logic       rd_busy;
   } status_type;

endpackage

@@ src/pps_req_if.sv @@
interface pps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [3:0]  slot;
   logic [15:0] task_id;
   logic [3:0]  task_priority;
   logic [15:0] arrival;
   logic [15:0] burst;

   modport source (
      output valid, opcode, slot, task_id, task_priority, arrival, burst,
      input  ready
   );
   modport sink (
      input  valid, opcode, slot, task_id, task_priority, arrival, burst,
      output ready
   );
endinterface

@@ src/pps_rsp_if.sv @@
interface pps_rsp_if;
   logic        valid;
   logic        ready;
   logic        ran_valid;
   logic [3:0]  ran_slot;
   logic [15:0] ran_id;
   logic        finished;
   logic [23:0] end_tick;
   logic [23:0] turnaround;
   logic [23:0] waiting;
   logic        all_done;
   logic [23:0] now;

   modport source (
      output valid, ran_valid, ran_slot, ran_id, finished, end_tick, turnaround,
             waiting, all_done, now,
      input  ready
   );
   modport sink (
      input  valid, ran_valid, ran_slot, ran_id, finished, end_tick, turnaround,
             waiting, all_done, now,
      output ready
   );
endinterface

@@ src/pps_csr_if.sv @@
interface pps_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] entries_in_use;

   modport source (
      output valid, entries_in_use,
      input  ready
   );
   modport sink (
      input  valid, entries_in_use,
      output ready
   );
endinterface

@@ src/pps_ram.sv @@
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/pps_ctrl.sv @@
module pps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   input  logic                 rsp_ready,
   input  pps_pkg::status_type  stat,
   output pps_pkg::cmd_type     cmd,
   output logic                 req_ready,
   output logic                 rsp_valid
);

   pps_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic pass_done;
   logic out_free;

   assign pass_done = stat.issue_done && !stat.rd_busy;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (pps_pkg::opcode_type'(req_opcode))
                  pps_pkg::OP_LOAD:    state_in = pps_pkg::ST_LOAD;
                  pps_pkg::OP_RESTART: state_in = pps_pkg::ST_SWEEP;
                  pps_pkg::OP_TICK,
                  pps_pkg::OP_NOP:     state_in = pps_pkg::ST_SCAN;
               endcase
            end
         end
         pps_pkg::ST_LOAD: state_in = pps_pkg::ST_SCAN;
         pps_pkg::ST_SWEEP: begin
            if (pass_done) state_in = pps_pkg::ST_SCAN;
         end
         pps_pkg::ST_SCAN: begin
            if (pass_done) begin
               state_in = (stat.op == pps_pkg::OP_TICK) ? pps_pkg::ST_UPDATE
                                                         : pps_pkg::ST_RESULT;
            end
         end
         pps_pkg::ST_UPDATE: state_in = pps_pkg::ST_FIGURE;
         pps_pkg::ST_FIGURE: state_in = pps_pkg::ST_RESULT;
         pps_pkg::ST_RESULT: begin
            if (out_free) state_in = pps_pkg::ST_IDLE;
         end
         default: state_in = pps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         pps_pkg::ST_LOAD:   cmd.load_wr = 1'b1;
         pps_pkg::ST_SWEEP: begin
            cmd.sweep   = 1'b1;
            cmd.clr_cnt = pass_done;
         end
         pps_pkg::ST_SCAN:   cmd.scan   = 1'b1;
         pps_pkg::ST_UPDATE: cmd.update = 1'b1;
         pps_pkg::ST_FIGURE: cmd.figure = 1'b1;
         pps_pkg::ST_RESULT: cmd.out_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready)        rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/pps_datapath.sv @@
module pps_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pps_pkg::cmd_type     cmd,
   output pps_pkg::status_type  stat,
   input  logic [1:0]           req_opcode,
   input  logic [3:0]           req_slot,
   input  logic [15:0]          req_task_id,
   input  logic [3:0]           req_task_priority,
   input  logic [15:0]          req_arrival,
   input  logic [15:0]          req_burst,
   input  logic                 csr_wr,
   input  logic [4:0]           csr_entries,
   output logic                 rsp_ran_valid,
   output logic [3:0]           rsp_ran_slot,
   output logic [15:0]          rsp_ran_id,
   output logic                 rsp_finished,
   output logic [23:0]          rsp_end_tick,
   output logic [23:0]          rsp_turnaround,
   output logic [23:0]          rsp_waiting,
   output logic                 rsp_all_done,
   output logic [23:0]          rsp_now
);

   localparam int IDX_W  = pps_pkg::IDX_W;
   localparam int CNT_W  = pps_pkg::CNT_W;
   localparam int TIME_W = pps_pkg::TIME_W;

   // latched item
   pps_pkg::opcode_type op_ff;
   logic [3:0]          slot_ff;
   pps_pkg::task_type   load_task_ff;

   logic [pps_pkg::ENTRY_W-1:0] entries_ff;

   // scan / sweep pass
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [CNT_W-1:0] n_active;
   logic [CNT_W-1:0] limit;
   logic             issue;
   logic             issue_done;

   // best candidate
   logic              found_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   pps_pkg::task_type best_task_ff;
   logic [15:0]       best_rem_ff;
   logic [CNT_W-1:0]  busy_ff;

   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] fin_ff;
   logic [TIME_W-1:0] tat_ff;
   logic              ran_ff;
   logic              fin_flag_ff;

   // memories
   pps_pkg::task_type table_rd;
   logic [$bits(pps_pkg::task_type)-1:0] table_rd_raw;
   logic [15:0]       rem_rd;
   logic              slot_ok;
   logic              rem_wr_en;
   logic [IDX_W-1:0]  rem_wr_addr;
   logic [15:0]       rem_wr_data;

   logic rem_nz;
   logic eligible;
   logic better;
   logic [TIME_W-1:0] wait_val;

   // output register
   logic              o_ran_ff;
   logic [3:0]        o_slot_ff;
   logic [15:0]       o_id_ff;
   logic              o_fin_ff;
   logic [TIME_W-1:0] o_fin_time_ff;
   logic [TIME_W-1:0] o_tat_ff;
   logic [TIME_W-1:0] o_wait_ff;
   logic              o_all_done_ff;
   logic [TIME_W-1:0] o_now_ff;

   always_comb begin
      if (32'(entries_ff) > pps_pkg::MAX_TASKS) n_active = CNT_W'(pps_pkg::MAX_TASKS);
      else                                      n_active = CNT_W'(entries_ff);
   end

   assign limit      = cmd.sweep ? CNT_W'(pps_pkg::MAX_TASKS) : n_active;
   assign issue_done = (cnt_ff == limit);
   assign issue      = (cmd.sweep || cmd.scan) && !issue_done;
   assign slot_ok    = 32'(slot_ff) < pps_pkg::MAX_TASKS;

   always_comb begin
      cnt_in = cnt_ff;
      priority if (cmd.accept || cmd.clr_cnt) cnt_in = '0;
      else if (issue)                          cnt_in = cnt_ff + CNT_W'(1);
   end

   assign stat.op         = op_ff;
   assign stat.issue_done = issue_done;
   assign stat.rd_busy    = rd_vld_ff;

   pps_ram #(
      .WIDTH ($bits(pps_pkg::task_type)),
      .DEPTH (pps_pkg::MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.load_wr && slot_ok),
      .wr_addr (IDX_W'(slot_ff)),
      .wr_data (load_task_ff),
      .rd_en   (issue),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (table_rd_raw)
   );

   assign table_rd = pps_pkg::task_type'(table_rd_raw);

   // remaining time: written by load, restart sweep and the tick update
   always_comb begin
      rem_wr_en   = 1'b0;
      rem_wr_addr = IDX_W'(slot_ff);
      rem_wr_data = load_task_ff.burst;
      if (cmd.load_wr) begin
         rem_wr_en = slot_ok;
      end else if (cmd.sweep && rd_vld_ff) begin
         rem_wr_en   = 1'b1;
         rem_wr_addr = rd_idx_ff;
         rem_wr_data = table_rd.burst;
      end else if (cmd.update && found_ff) begin
         rem_wr_en   = 1'b1;
         rem_wr_addr = best_idx_ff;
         rem_wr_data = best_rem_ff - 16'd1;
      end
   end

   pps_ram #(
      .WIDTH (16),
      .DEPTH (pps_pkg::MAX_TASKS)
   ) u_remaining (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (issue),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rem_rd)
   );

   assign rem_nz   = (rem_rd != 16'd0);
   assign eligible = rem_nz && (TIME_W'(table_rd.arrival) <= now_ff);
   // strict compare keeps the lowest slot on a tie
   assign better   = eligible && (!found_ff || (table_rd.prio < best_task_ff.prio));

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff  <= '0;
         cnt_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         busy_ff     <= '0;
         now_ff      <= '0;
         ran_ff      <= 1'b0;
         fin_flag_ff <= 1'b0;
         op_ff       <= pps_pkg::OP_NOP;
      end else begin
         cnt_ff    <= cnt_in;
         rd_vld_ff <= issue;
         if (csr_wr) entries_ff <= csr_entries;
         if (cmd.accept) begin
            op_ff       <= pps_pkg::opcode_type'(req_opcode);
            found_ff    <= 1'b0;
            busy_ff     <= '0;
            ran_ff      <= 1'b0;
            fin_flag_ff <= 1'b0;
            if (pps_pkg::opcode_type'(req_opcode) == pps_pkg::OP_RESTART) now_ff <= '0;
         end
         if (cmd.scan && rd_vld_ff) begin
            busy_ff <= busy_ff + CNT_W'(rem_nz);
            if (better) found_ff <= 1'b1;
         end
         if (cmd.update) begin
            ran_ff      <= found_ff;
            fin_flag_ff <= found_ff && (best_rem_ff == 16'd1);
            if (now_ff != pps_pkg::TIME_MAX) now_ff <= now_ff + TIME_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff[IDX_W-1:0];
      if (cmd.accept) begin
         slot_ff              <= req_slot;
         load_task_ff.id      <= req_task_id;
         load_task_ff.prio    <= req_task_priority;
         load_task_ff.arrival <= req_arrival;
         load_task_ff.burst   <= req_burst;
      end
      if (cmd.scan && rd_vld_ff && better) begin
         best_idx_ff  <= rd_idx_ff;
         best_task_ff <= table_rd;
         best_rem_ff  <= rem_rd;
      end
      if (cmd.update) begin
         fin_ff <= (now_ff == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX : now_ff + TIME_W'(1);
      end
      if (cmd.figure) begin
         tat_ff <= fin_ff - TIME_W'(best_task_ff.arrival);
      end
   end

   assign wait_val = (tat_ff >= TIME_W'(best_task_ff.burst))
                     ? tat_ff - TIME_W'(best_task_ff.burst) : '0;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_ran_ff      <= ran_ff;
         o_slot_ff     <= ran_ff ? 4'(best_idx_ff) : 4'd0;
         o_id_ff       <= ran_ff ? best_task_ff.id : 16'd0;
         o_fin_ff      <= fin_flag_ff;
         o_fin_time_ff <= fin_flag_ff ? fin_ff : '0;
         o_tat_ff      <= fin_flag_ff ? tat_ff : '0;
         o_wait_ff     <= fin_flag_ff ? wait_val : '0;
         // the finishing task was still counted as busy during the scan
         o_all_done_ff <= (busy_ff == CNT_W'(fin_flag_ff));
         o_now_ff      <= now_ff;
      end
   end

   assign rsp_ran_valid   = o_ran_ff;
   assign rsp_ran_slot    = o_slot_ff;
   assign rsp_ran_id      = o_id_ff;
   assign rsp_finished    = o_fin_ff;
   assign rsp_end_tick    = o_fin_time_ff;
   assign rsp_turnaround  = o_tat_ff;
   assign rsp_waiting     = o_wait_ff;
   assign rsp_all_done    = o_all_done_ff;
   assign rsp_now         = o_now_ff;

endmodule

@@ src/preemptive_priority_scheduler.sv @@
// channel   dir  handshake      payload
// req_chan  in   valid/ready    opcode, slot, task_id, task_priority, arrival, burst
// rsp_chan  out  valid/ready    ran_valid ... now, one item per request item
// csr_chan  in   valid/ready    entries_in_use, always ready
//
// a tick steps through accept, n table reads (n = active slots, 0 to MAX_TASKS), the
// read return, pass end, update, figure and result load; a no-op, load or restart skips
// update and figure, a load adds a table write before the scan and a restart a copy
// sweep of all MAX_TASKS slots; with no slot in use the scan issues no table read
// synchronous reset clears the tick counter, slot count and handshake state
// a new item is taken while the previous result waits; a stalled result holds the
// block in its result step until the result register frees up
module preemptive_priority_scheduler (
   input  logic     clock,
   input  logic     reset,
   pps_req_if.sink  req_chan,
   pps_rsp_if.source rsp_chan,
   pps_csr_if.sink  csr_chan
);

   pps_pkg::cmd_type    cmd;
   pps_pkg::status_type stat;

   assign csr_chan.ready = 1'b1;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .rsp_ready  (rsp_chan.ready),
      .stat       (stat),
      .cmd        (cmd),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid)
   );

   pps_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_chan.opcode),
      .req_slot          (req_chan.slot),
      .req_task_id       (req_chan.task_id),
      .req_task_priority (req_chan.task_priority),
      .req_arrival       (req_chan.arrival),
      .req_burst         (req_chan.burst),
      .csr_wr            (csr_chan.valid && csr_chan.ready),
      .csr_entries       (csr_chan.entries_in_use),
      .rsp_ran_valid     (rsp_chan.ran_valid),
      .rsp_ran_slot      (rsp_chan.ran_slot),
      .rsp_ran_id        (rsp_chan.ran_id),
      .rsp_finished      (rsp_chan.finished),
      .rsp_end_tick      (rsp_chan.end_tick),
      .rsp_turnaround    (rsp_chan.turnaround),
      .rsp_waiting       (rsp_chan.waiting),
      .rsp_all_done      (rsp_chan.all_done),
      .rsp_now           (rsp_chan.now)
   );

   // a result is never written over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register loaded while previous result pending");

   // one item at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second item accepted while one is in progress");

   // no memory read in flight when idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !stat.rd_busy)
      else $error("table read pending while ready for a new item");

endmodule
